// ===== rtl/cbf_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the CRC byte framer/checker.
`timescale 1ns / 1ps
package cbf_pkg;

  // CRC-8/SMBus: x^8 + x^2 + x + 1, initial value zero
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [7:0] CRC_INIT     = 8'h00;
  localparam logic [6:0] BUS_ADDR_RST = 7'd8;
  localparam logic [7:0] CNT_MAX      = 8'hFF;

  // Operation codes on the opcode field
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // One result offered by the byte stage to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_crc;
    logic       crc_mismatch;
    logic       end_of_run;
    logic       rd;      // read result: update the mismatch counter
    logic       clr;     // first byte of a read: restart the count
  } res_t;

  // Fold one byte into a running CRC, MSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/cbf_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface cbf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] reg_address;
  logic [7:0] data_byte;
  logic [7:0] received_crc;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, opcode, reg_address, data_byte, received_crc,
                  first_byte, last_byte, input ready);
  modport sink   (input valid, opcode, reg_address, data_byte, received_crc,
                  first_byte, last_byte, output ready);
endinterface

interface cbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_crc;
  logic       crc_mismatch;
  logic [7:0] mismatch_count;
  logic       end_of_run;

  modport source (output valid, out_byte, is_crc, crc_mismatch, mismatch_count,
                  end_of_run, input ready);
  modport sink   (input valid, out_byte, is_crc, crc_mismatch, mismatch_count,
                  end_of_run, output ready);
endinterface

// ===== rtl/cbf_prefix.sv =====
// Header CRC: folds the address bytes that precede the first payload byte.
`timescale 1ns / 1ps
module cbf_prefix (
  input  logic [6:0] bus_addr,
  input  logic       opcode,
  input  logic       first_byte,
  input  logic [7:0] reg_address,
  output logic [7:0] prefix_crc
);

  logic [7:0] waddr;
  logic [7:0] raddr;
  logic [7:0] crc_w;
  logic [7:0] crc_r;

  // Derive the write and read address bytes from the device address
  assign waddr = {bus_addr, 1'b0};
  assign raddr = {bus_addr, 1'b1};

  // Write header covers write address and register; read adds read address
  assign crc_w = cbf_pkg::crc_feed(cbf_pkg::crc_feed(cbf_pkg::CRC_INIT, waddr), reg_address);
  assign crc_r = cbf_pkg::crc_feed(crc_w, raddr);

  // Later bytes of a transfer start from the initial value
  always_comb begin
    if (!first_byte) begin
      prefix_crc = cbf_pkg::CRC_INIT;
    end else if (opcode == cbf_pkg::OP_READ) begin
      prefix_crc = crc_r;
    end else begin
      prefix_crc = crc_w;
    end
  end

endmodule

// ===== rtl/cbf_stage.sv =====
// Input register: holds one item, finishes its CRC and offers its results in order.
`timescale 1ns / 1ps
module cbf_stage (
  input  logic              clk,
  input  logic              rst_n,
  cbf_in_if.sink            in_ch,
  input  logic [7:0]        prefix_crc,
  input  logic              space,
  output cbf_pkg::res_t     res
);

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_phase_r, s1_phase_nxt;
  logic       s1_op_r;
  logic [7:0] s1_data_r;
  logic [7:0] s1_rcrc_r;
  logic       s1_first_r;
  logic       s1_last_r;
  logic [7:0] s1_prefix_r;

  logic       accept;
  logic       emit;
  logic       final_res;
  logic [7:0] crc;

  // Last result of the item: a read has one, a write its CRC second
  assign final_res = (s1_op_r == cbf_pkg::OP_READ) || s1_phase_r;
  assign emit      = s1_valid_r && space;
  assign in_ch.ready = !s1_valid_r || (emit && final_res);
  assign accept    = in_ch.valid && in_ch.ready;

  // Fold the payload byte into the header CRC
  assign crc = cbf_pkg::crc_feed(s1_prefix_r, s1_data_r);

  // Build the offered result
  always_comb begin
    res.valid        = s1_valid_r;
    res.out_byte     = s1_data_r;
    res.is_crc       = 1'b0;
    res.crc_mismatch = 1'b0;
    res.end_of_run   = s1_last_r;
    res.rd           = 1'b0;
    res.clr          = 1'b0;
    if (s1_op_r == cbf_pkg::OP_READ) begin
      res.crc_mismatch = (crc != s1_rcrc_r);
      res.rd           = 1'b1;
      res.clr          = s1_first_r;
    end else if (s1_phase_r) begin
      res.out_byte     = crc;
      res.is_crc       = 1'b1;
    end else begin
      res.end_of_run   = 1'b0;
    end
  end

  // Advance the stage: refill on accept, step to the CRC half of a write
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_phase_nxt = s1_phase_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_phase_nxt = 1'b0;
    end else if (emit && final_res) begin
      s1_valid_nxt = 1'b0;
      s1_phase_nxt = 1'b0;
    end else if (emit) begin
      s1_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_phase_r <= s1_phase_nxt;
    end
  end

  // Capture the item payload on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_ch.opcode;
      s1_data_r   <= in_ch.data_byte;
      s1_rcrc_r   <= in_ch.received_crc;
      s1_first_r  <= in_ch.first_byte;
      s1_last_r   <= in_ch.last_byte;
      s1_prefix_r <= prefix_crc;
    end
  end

endmodule

// ===== rtl/cbf_outreg.sv =====
// Output register and saturating mismatch counter.
`timescale 1ns / 1ps
module cbf_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  cbf_pkg::res_t     res,
  output logic              space,
  cbf_out_if.source         out_ch
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] cnt_base;
  logic       load;

  logic [7:0] out_byte_r;
  logic       is_crc_r;
  logic       mm_r;
  logic [7:0] count_r;
  logic       eor_r;

  // Take a new result when the register is empty or being drained
  assign space = !out_valid_r || out_ch.ready;
  assign load  = res.valid && space;

  // Count mismatches of the current read, restarting on its first byte
  always_comb begin
    cnt_base = res.clr ? 8'd0 : cnt_r;
    cnt_nxt  = cnt_r;
    if (load && res.rd) begin
      cnt_nxt = (res.crc_mismatch && (cnt_base != cbf_pkg::CNT_MAX)) ?
                cnt_base + 8'd1 : cnt_base;
    end
  end

  // Hold valid until the result transfers
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= res.out_byte;
      is_crc_r   <= res.is_crc;
      mm_r       <= res.crc_mismatch;
      count_r    <= res.rd ? cnt_nxt : 8'd0;
      eor_r      <= res.end_of_run;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_byte       = out_byte_r;
  assign out_ch.is_crc         = is_crc_r;
  assign out_ch.crc_mismatch   = mm_r;
  assign out_ch.mismatch_count = count_r;
  assign out_ch.end_of_run     = eor_r;

endmodule

// ===== rtl/i2c_crc8_byte_framer_checker_top.sv =====
// Top level of the CRC-8 byte framer and checker.
`timescale 1ns / 1ps
// CRC-8/SMBus (poly 0x07, init 0) framer and checker, one payload byte per input
// transfer. A write item (opcode 0) yields two results, the data byte and then its
// CRC; a read item (opcode 1) yields one result with the mismatch flag and the
// saturating per-read mismatch count. On the first byte of a transfer the CRC also
// covers the address bytes built from cfg (write = addr*2, read = addr*2+1) and the
// register address. An item is held in the item register and its results pass through
// the output register; the item register takes a new item only as it offers the last
// result of the one it holds. The single output register sets the rate: one result per
// cycle while the output channel is ready. Write cfg only while the block is idle.
module i2c_crc8_byte_framer_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  cbf_in_if.sink     in_ch,
  cbf_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  logic [6:0]    bus_addr_r;
  logic [7:0]    prefix_crc;
  logic          space;
  cbf_pkg::res_t res;

  // Device address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_addr_r <= cbf_pkg::BUS_ADDR_RST;
    end else if (cfg_wr_en) begin
      bus_addr_r <= cfg_wr_data;
    end
  end

  // Header CRC on the incoming item
  cbf_prefix u_prefix (
    .bus_addr    (bus_addr_r),
    .opcode      (in_ch.opcode),
    .first_byte  (in_ch.first_byte),
    .reg_address (in_ch.reg_address),
    .prefix_crc  (prefix_crc)
  );

  // Item register and result selection
  cbf_stage u_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .prefix_crc (prefix_crc),
    .space      (space),
    .res        (res)
  );

  // Result register and mismatch counter
  cbf_outreg u_outreg (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // A pending result that cannot move blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && !space |-> !in_ch.ready)
    else $error("input ready while item stage is stalled");

  // A CRC result never carries read status
  a_crc_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_crc |-> !out_ch.crc_mismatch && out_ch.mismatch_count == 8'd0)
    else $error("CRC result with mismatch status");

  // A flagged mismatch is always counted
  a_mismatch_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.crc_mismatch |-> out_ch.mismatch_count != 8'd0)
    else $error("mismatch flagged with zero count");
`endif

endmodule

// ===== tb/sv/tb_cbf_pkg.sv =====
`timescale 1ns / 1ps
// Testbench types and CRC-8 helpers shared by the stimulus and the result checker.
package tb_cbf_pkg;

  // One output transfer as the checker sees it
  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_crc;
    logic       crc_mismatch;
    logic [7:0] count;
    logic       end_of_run;
  } bus_result_t;

  // Shift one byte through the CRC-8 register, one bit at a time, MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
    end
    return c;
  endfunction

  // CRC of one payload byte; the first byte also covers the address bytes
  function automatic logic [7:0] frame_crc(input logic [6:0] tgt_addr, input logic is_read,
                                           input logic [7:0] reg_sel, input logic [7:0] data,
                                           input logic first);
    logic [7:0] c;
    c = 8'h00;
    if (first) begin
      c = crc8_fold(c, {tgt_addr, 1'b0});
      c = crc8_fold(c, reg_sel);
      if (is_read) begin
        c = crc8_fold(c, {tgt_addr, 1'b1});
      end
    end
    return crc8_fold(c, data);
  endfunction

endpackage

// ===== tb/sv/tb_cbf_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker: predicts the framer/checker output stream and compares each transfer.
module tb_cbf_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  cbf_in_if          in_ch,
  cbf_out_if         out_ch,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  output int         n_fail,
  output int         n_pending
);

  logic [6:0]              bus_addr;
  logic [7:0]              read_mismatches;
  tb_cbf_pkg::bus_result_t expected_bus_bytes[$];

  // Queue the results that one input transfer produces
  task automatic predict_byte_results(input logic op, input logic [7:0] reg_sel,
                                      input logic [7:0] data, input logic [7:0] rx_crc,
                                      input logic first, input logic last);
    logic [7:0] crc;
    logic       mm;
    crc = tb_cbf_pkg::frame_crc(bus_addr, op == cbf_pkg::OP_READ, reg_sel, data, first);
    if (op == cbf_pkg::OP_WRITE) begin
      expected_bus_bytes.push_back({data, 1'b0, 1'b0, 8'h00, 1'b0});
      expected_bus_bytes.push_back({crc, 1'b1, 1'b0, 8'h00, last});
    end else begin
      if (first) begin
        read_mismatches = 8'h00;
      end
      mm = (crc != rx_crc);
      if (mm && read_mismatches != cbf_pkg::CNT_MAX) begin
        read_mismatches = read_mismatches + 8'd1;
      end
      expected_bus_bytes.push_back({data, 1'b0, mm, read_mismatches, last});
    end
  endtask

  // Compare results first, then predict from the input, then track config writes
  always @(posedge clk) begin
    tb_cbf_pkg::bus_result_t got;
    tb_cbf_pkg::bus_result_t want;
    if (!rst_n) begin
      bus_addr        = cbf_pkg::BUS_ADDR_RST;
      read_mismatches = 8'h00;
      n_fail          = 0;
      expected_bus_bytes.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_byte, out_ch.is_crc, out_ch.crc_mismatch, out_ch.mismatch_count,
               out_ch.end_of_run};
        if (expected_bus_bytes.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected result byte=%h is_crc=%b mm=%b cnt=%h eor=%b", $time,
                   got.byte_val, got.is_crc, got.crc_mismatch, got.count, got.end_of_run);
        end else begin
          want = expected_bus_bytes.pop_front();
          if (got !== want) begin
            n_fail++;
            $display("%0t: mismatch expected byte=%h is_crc=%b mm=%b cnt=%h eor=%b", $time,
                     want.byte_val, want.is_crc, want.crc_mismatch, want.count,
                     want.end_of_run);
            $display("%0t:          actual   byte=%h is_crc=%b mm=%b cnt=%h eor=%b", $time,
                     got.byte_val, got.is_crc, got.crc_mismatch, got.count, got.end_of_run);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_byte_results(in_ch.opcode, in_ch.reg_address, in_ch.data_byte,
                             in_ch.received_crc, in_ch.first_byte, in_ch.last_byte);
      end
      if (cfg_wr_en) begin
        bus_addr = cfg_wr_data;
      end
    end
    n_pending = expected_bus_bytes.size();
  end

endmodule

// ===== tb/sv/tb_i2c_crc8_byte_framer_checker_top.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the CRC-8 byte framer/checker.
module tb_i2c_crc8_byte_framer_checker_top;

  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [6:0] cfg_wr_data;
  logic [6:0] tgt_addr;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         n_fail;
  int         n_pending;
  int         stall_cycles;

  cbf_in_if  in_ch ();
  cbf_out_if out_ch ();

  i2c_crc8_byte_framer_checker_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tb_cbf_result_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .n_fail     (n_fail),
    .n_pending  (n_pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Abort when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_i2c_crc8_byte_framer_checker_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one item, idling first at random; returns at the falling edge after the transfer
  task automatic send_item(input logic op, input logic [7:0] reg_sel, input logic [7:0] data,
                           input logic [7:0] rx_crc, input logic first, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid        <= 1'b0;
      in_ch.data_byte    <= 8'($urandom);
      in_ch.received_crc <= 8'($urandom);
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.reg_address  <= reg_sel;
    in_ch.data_byte    <= data;
    in_ch.received_crc <= rx_crc;
    in_ch.first_byte   <= first;
    in_ch.last_byte    <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Read byte whose CRC is correct, optionally xor-corrupted
  task automatic send_read(input logic [7:0] reg_sel, input logic [7:0] data,
                           input logic first, input logic last, input logic [7:0] flip);
    send_item(cbf_pkg::OP_READ, reg_sel, data,
              tb_cbf_pkg::frame_crc(tgt_addr, 1'b1, reg_sel, data, first) ^ flip,
              first, last);
  endtask

  // One transfer of random payload; bad_pct of the read bytes carry a wrong CRC
  task automatic send_transfer(input logic op, input int len, input int bad_pct,
                               input logic drop_first, input logic drop_last);
    logic [7:0] reg_sel;
    logic [7:0] flip;
    logic       first;
    logic       last;
    reg_sel = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) && !drop_first;
      last  = (i == len - 1) && !drop_last;
      flip  = ($urandom_range(99) < bad_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (op == cbf_pkg::OP_WRITE) begin
        send_item(cbf_pkg::OP_WRITE, reg_sel, 8'($urandom), 8'($urandom), first, last);
      end else begin
        send_read(reg_sel, 8'($urandom), first, last, flip);
      end
    end
  endtask

  // Mostly well-formed transfers, some broken framing and some raw noise
  task automatic run_random(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                  1'($urandom));
        sent++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
        send_transfer(1'($urandom), len, 30, $urandom_range(9) == 0,
                      $urandom_range(9) == 0);
        sent += len;
      end
    end
  endtask

  // Hold the sender until every expected result has been seen
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // Write the device address while the block is idle
  task automatic write_bus_address(input logic [6:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    tgt_addr     = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    tgt_addr           = cbf_pkg::BUS_ADDR_RST;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = cbf_pkg::OP_WRITE;
    in_ch.reg_address  = '0;
    in_ch.data_byte    = '0;
    in_ch.received_crc = '0;
    in_ch.first_byte   = 1'b0;
    in_ch.last_byte    = 1'b0;
    send_idle_pct      = 30;
    recv_idle_pct      = 49;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, both operations, framing corner cases, reset address
    send_item(cbf_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
    send_item(cbf_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    send_item(cbf_pkg::OP_WRITE, 8'hFF, 8'h80, 8'h00, 1'b0, 1'b0);
    send_item(cbf_pkg::OP_WRITE, 8'hFF, 8'h01, 8'h00, 1'b0, 1'b1);
    send_item(cbf_pkg::OP_WRITE, 8'h33, 8'h7F, 8'hAA, 1'b0, 1'b0);
    send_read(8'h00, 8'h00, 1'b1, 1'b1, 8'h00);
    send_read(8'hFF, 8'hFF, 1'b1, 1'b0, 8'hFF);
    send_read(8'hFF, 8'h55, 1'b0, 1'b0, 8'h00);
    send_read(8'hFF, 8'hAA, 1'b0, 1'b0, 8'h01);
    send_read(8'hFF, 8'h00, 1'b0, 1'b1, 8'h80);
    // read with no opening byte keeps counting
    send_read(8'h12, 8'h12, 1'b0, 1'b1, 8'h40);
    // a write between reads leaves the count alone
    send_item(cbf_pkg::OP_WRITE, 8'h5A, 8'hA5, 8'hFF, 1'b1, 1'b1);
    send_read(8'h13, 8'h34, 1'b0, 1'b0, 8'h02);
    send_read(8'h80, 8'h80, 1'b1, 1'b1, 8'h00);
    send_read(8'h01, 8'hFE, 1'b1, 1'b1, 8'h80);
    wait_drained();

    // Lowest address, sender 30% / receiver 49% idle
    write_bus_address(7'd0);
    run_random(250);
    wait_drained();

    // Highest address, roles swapped, with a full drain midway
    write_bus_address(7'd127);
    send_idle_pct = 49;
    recv_idle_pct = 30;
    run_random(125);
    wait_drained();
    run_random(125);
    wait_drained();

    // Random address, no idling; one long bad read drives the count into saturation
    write_bus_address(7'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(115);
    send_transfer(cbf_pkg::OP_READ, 270, 100, 1'b0, 1'b0);
    run_random(115);
    wait_drained();

    repeat (6) @(posedge clk);
    @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_i2c_crc8_byte_framer_checker_top: PASS");
    end else begin
      $display("tb_i2c_crc8_byte_framer_checker_top: FAIL");
    end
    $finish;
  end

endmodule
